/* sv/b2da_pkg.sv */
`timescale 1ns / 1ps
package b2da_pkg;

   localparam int VALUE_W = 64;
   localparam int WIDTH_W = 5;
   localparam int CHAR_W  = 6;
   localparam int DIGIT_W = 4;

   localparam int DEF_VALUE_BITS = 64;
   localparam int DEF_MAX_DIGITS = 20;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SKIP,
      ST_EMIT
   } b2da_state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic next_digit;
   } b2da_ctl_type;

endpackage

/* sv/b2da_if.sv */
`timescale 1ns / 1ps
interface b2da_req_if;
   import b2da_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [WIDTH_W-1:0] width;

   modport source (output valid, output value, output width, input ready);
   modport sink (input valid, input value, input width, output ready);
endinterface

interface b2da_rsp_if;
   import b2da_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

/* sv/b2da_dabble.sv */
`timescale 1ns / 1ps
module b2da_dabble #(
   parameter int VALUE_BITS = b2da_pkg::DEF_VALUE_BITS,
   parameter int MAX_DIGITS = b2da_pkg::DEF_MAX_DIGITS
) (
   input  logic                                clock,
   input  b2da_pkg::b2da_ctl_type              ctl,
   input  logic [b2da_pkg::VALUE_W-1:0]        value,
   output logic [b2da_pkg::DIGIT_W-1:0]        top_digit
);
   import b2da_pkg::*;

   localparam int BCD_W = MAX_DIGITS * DIGIT_W;

   logic [VALUE_BITS-1:0] bin_ff;
   logic [VALUE_BITS-1:0] bin_in;
   logic [BCD_W-1:0]      bcd_ff;
   logic [BCD_W-1:0]      bcd_in;
   logic [BCD_W-1:0]      bcd_adj;

   // add-3 correction, every digit in parallel
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctl.load) begin
         bin_in = value[VALUE_BITS-1:0];
         bcd_in = '0;
      end else if (ctl.shift) begin
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
      end else if (ctl.next_digit) begin
         bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

`ifndef NO_ASSERTIONS
   // the leading digit is a decimal digit after a load
   a_top_decimal: assert property (@(posedge clock)
      $past(ctl.load) |-> top_digit <= 4'd9)
      else $error("leading digit left decimal range");
   a_ctl_exclusive: assert property (@(posedge clock)
      $onehot0({ctl.load, ctl.shift, ctl.next_digit}))
      else $error("more than one dabble operation at once");
   a_load_clears: assert property (@(posedge clock)
      ctl.load |=> top_digit == 4'd0)
      else $error("digit register not cleared on load");
`endif

endmodule

/* sv/binary_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// Binary to decimal ASCII converter.
// req channel: one item carries an unsigned value (low VALUE_BITS bits used)
// and a width. Width 0 emits the natural digit count (at least one), a
// nonzero width emits exactly that many digits (saturated at MAX_DIGITS),
// zero padded on the left or keeping only the low digits.
// rsp channel: one item per character, most significant first, with last
// set on the units digit. char_code is the ASCII code '0' to '9'.
// After acceptance the value runs through bit-serial double dabble, then for
// n characters the digits above them are dropped one at a time, and the
// characters follow at one per cycle while the rsp receiver keeps up. The
// next number is accepted once the block is back in idle after the last
// character is registered.
// One number is in work at a time; req ready is high only while idle. The
// next number may be accepted while the final character still waits.
// A stalled rsp receiver holds the character in the output register and
// freezes the digit sequence until it is taken.
// Reset (synchronous, active high) returns to idle and drops any pending
// character.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = b2da_pkg::DEF_VALUE_BITS,
   parameter int MAX_DIGITS = b2da_pkg::DEF_MAX_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   b2da_req_if.sink    req_if,
   b2da_rsp_if.source  rsp_if
);
   import b2da_pkg::*;

   localparam int STEP_W = $clog2(VALUE_BITS + 1);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

   b2da_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  remaining_ff, remaining_in;
   logic [CNT_W-1:0]  target_ff, target_in;
   logic              fixed_ff, fixed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;

   b2da_ctl_type       ctl;
   logic [DIGIT_W-1:0] top_digit;
   logic               slot_free;

   b2da_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dabble (
      .clock     (clock),
      .ctl       (ctl),
      .value     (req_if.value),
      .top_digit (top_digit)
   );

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      remaining_in = remaining_ff;
      target_in    = target_ff;
      fixed_in     = fixed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               ctl.load     = 1'b1;
               step_in      = '0;
               remaining_in = CNT_W'(MAX_DIGITS);
               priority if (req_if.width == '0) begin
                  fixed_in  = 1'b0;
                  target_in = CNT_W'(1);
               end else if (req_if.width > WIDTH_W'(MAX_DIGITS)) begin
                  fixed_in  = 1'b1;
                  target_in = CNT_W'(MAX_DIGITS);
               end else begin
                  fixed_in  = 1'b1;
                  target_in = CNT_W'(req_if.width);
               end
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            ctl.shift = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(VALUE_BITS - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop digits above the requested width, or leading zeros
            if ((remaining_ff > target_ff) && (fixed_ff || top_digit == '0)) begin
               ctl.next_digit = 1'b1;
               remaining_in   = remaining_ff - CNT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               ctl.next_digit = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_char_in    = ASCII_ZERO + CHAR_W'(top_digit);
               rsp_last_in    = (remaining_ff == CNT_W'(1));
               remaining_in   = remaining_ff - CNT_W'(1);
               if (remaining_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      fixed_ff    <= fixed_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.char_code = rsp_char_ff;
   assign rsp_if.last      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_shift_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP && $past(state_ff) == ST_SHIFT) |->
         step_ff == STEP_W'(VALUE_BITS))
      else $error("conversion left shift phase early");
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> remaining_ff != '0)
      else $error("emit with no digits left");
   a_remaining_max: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= CNT_W'(MAX_DIGITS))
      else $error("digit count above store depth");
   a_char_decimal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_ff >= ASCII_ZERO && rsp_char_ff <= ASCII_ZERO + 6'd9))
      else $error("character outside decimal digits");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free && remaining_ff == CNT_W'(1)) |=>
         (rsp_last_ff && state_ff == ST_IDLE))
      else $error("final character not marked");
`endif

endmodule

/* bench/binary_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
module binary_to_decimal_ascii_tb;
   import b2da_pkg::*;

   localparam int VALUE_BITS   = DEF_VALUE_BITS;
   localparam int MAX_DIGITS   = DEF_MAX_DIGITS;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = VALUE_BITS + 2 * MAX_DIGITS + 16;
   localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } digit_char_type;

   logic           clock = 1'b0;
   logic           reset;
   bit             idling_on;
   int unsigned    mismatches = 0;
   int unsigned    cycle_count;
   digit_char_type expected_chars [$];

   b2da_req_if req_if ();
   b2da_rsp_if rsp_if ();

   binary_to_decimal_ascii #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // queue the characters one number should produce, most significant first
   function automatic void predict_digits(logic [VALUE_W-1:0] value,
                                          logic [WIDTH_W-1:0] width);
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] digits [MAX_DIGITS];
      int unsigned        natural_count;
      int unsigned        count;
      digit_char_type     ch;
      rest = value & VALUE_MASK;
      natural_count = 1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digits[i] = DIGIT_W'(rest % 10);
         rest = rest / 10;
         if (digits[i] != 0) natural_count = i + 1;
      end
      if (width == 0) begin
         count = natural_count;
      end else if (width > MAX_DIGITS) begin
         count = MAX_DIGITS;
      end else begin
         count = 32'(width);
      end
      for (int k = 0; k < count; k++) begin
         ch.char_code = ASCII_ZERO + CHAR_W'(digits[count - 1 - k]);
         ch.last = (k == count - 1);
         expected_chars.push_back(ch);
      end
   endfunction

   // valid stays high after acceptance unless a gap is taken, so the next
   // call just replaces the payload
   task automatic send_number(logic [VALUE_W-1:0] value, logic [WIDTH_W-1:0] width);
      int unsigned gap;
      req_if.valid <= 1'b1;
      req_if.value <= value;
      req_if.width <= width;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      predict_digits(value, width);
      if (idling_on && $urandom_range(99) < 30) begin
         // long gaps can outlast a conversion so the block waits idle for input
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : $urandom_range(40, 250);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic release_numbers();
      req_if.valid <= 1'b0;
   endtask

   task automatic test_directed();
      idling_on = 1'b1;
      send_number(64'd0, 5'd0);
      send_number(64'd0, 5'd20);
      send_number(64'd0, 5'd31);
      send_number(64'd1, 5'd0);
      send_number(64'd9, 5'd0);
      send_number(64'd10, 5'd0);
      send_number(64'd5, 5'd1);
      send_number(64'd1234, 5'd1);
      send_number(64'd12345, 5'd3);
      send_number(64'd12345, 5'd8);
      send_number(64'd100, 5'd2);
      send_number(64'd7, 5'd21);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 5'd0);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 5'd5);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 5'd20);
      send_number(64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
      send_number(64'd10000000000000000000, 5'd0);
      send_number(64'd9999999999999999999, 5'd0);
      send_number(64'h8000_0000_0000_0000, 5'd0);
      send_number(64'h5555_5555_5555_5555, 5'b10101);
      send_number(64'hAAAA_AAAA_AAAA_AAAA, 5'b01010);
      release_numbers();
   endtask

   // digit lengths spread evenly, widths mostly natural or in range
   task automatic test_random_numbers(int unsigned items, bit stalls);
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] limit;
      logic [WIDTH_W-1:0] width;
      int unsigned        digit_count;
      idling_on = stalls;
      repeat (items) begin
         digit_count = $urandom_range(1, MAX_DIGITS);
         value = {$urandom, $urandom};
         if (digit_count < MAX_DIGITS) begin
            limit = 1;
            repeat (digit_count) limit = limit * 10;
            value = value % limit;
         end
         case ($urandom_range(9))
            0, 1, 2, 3: width = '0;
            4: width = WIDTH_W'($urandom_range(MAX_DIGITS + 1, 31));
            default: width = WIDTH_W'($urandom_range(1, MAX_DIGITS));
         endcase
         send_number(value, width);
      end
      release_numbers();
   endtask

   always @(posedge clock) begin : check_chars
      digit_char_type got;
      digit_char_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !idling_on || ($urandom_range(99) >= 30);
         if (rsp_if.valid && rsp_if.ready) begin
            got.char_code = rsp_if.char_code;
            got.last = rsp_if.last;
            if (expected_chars.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item: expected none, actual char %0d last %0b",
                        $time, got.char_code, got.last);
            end else begin
               want = expected_chars.pop_front();
               if (got.char_code !== want.char_code) begin
                  mismatches++;
                  $display("%0t: char_code mismatch: expected %0d, actual %0d",
                           $time, want.char_code, got.char_code);
               end
               if (got.last !== want.last) begin
                  mismatches++;
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, want.last, got.last);
               end
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d chars outstanding", $time, expected_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.value <= '0;
      req_if.width <= '0;
      idling_on = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_numbers(290, 1'b1);
      // shorter stretch with both sides always ready
      test_random_numbers(60, 1'b0);
      idling_on = 1'b1;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
